@@ design/svpd_pkg.sv @@
// Shared constants, types and helpers of the space vector PWM duty generator.
package svpd_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int CW = 34;

  // Arctangent of 2^-i as a fraction of one turn (2^32 per turn)
  localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  localparam logic signed [CW-1:0] CORDIC_K = 34'sd652032874;
  localparam logic [31:0] SQRT3_Q30    = 32'd1859775393;
  localparam logic [15:0] U_LIMIT      = 16'd18907;
  localparam logic [30:0] ONE_Q30      = 31'h4000_0000;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0] DIV6_MAGIC   = 32'hAAAA_AAAB;
  localparam logic [31:0] SIXTH_TURN   = 32'd715827882;
  localparam logic [15:0] SUPPLY_RESET = 16'd3072;
  localparam logic [15:0] PERIOD_RESET = 16'd3600;
  localparam int DIV_STEPS = 15;

  typedef enum logic [2:0] {
    SEC_1 = 3'd0, SEC_2 = 3'd1, SEC_3 = 3'd2,
    SEC_4 = 3'd3, SEC_5 = 3'd4, SEC_6 = 3'd5
  } sector_t;

  typedef enum logic {
    REG_SUPPLY = 1'b0,
    REG_PERIOD = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] duty_c;
    logic [15:0] duty_b;
    logic [15:0] duty_a;
    logic        motor;
  } duty_t;

  // Clamp a phase time to the range zero to one in Q.30
  function automatic logic [30:0] clamp_time(input logic signed [CW+1:0] t);
    logic [30:0] r;
    if (t < 0) begin
      r = '0;
    end else if (t > $signed({5'b0, ONE_Q30})) begin
      r = ONE_Q30;
    end else begin
      r = t[30:0];
    end
    return r;
  endfunction

endpackage

@@ design/space_vector_pwm_duty.sv @@
// Top level of the six-sector space vector PWM duty generator.
//
// Accepts one voltage command per clock cycle while s_tready is high and returns
// three phase compare values per command, in order. Results pass through the
// pipelined phase CORDIC, the one-bit-per-stage square root, the 15-stage
// modulation index divider and the two sine CORDICs; throughput is one command
// per cycle while the skid entry is empty.
// A two-entry output stage lets input transfers continue while a result waits.
// Registers: supply_voltage at byte address 0, pwm_period at byte address 4.
module space_vector_pwm_duty
  import svpd_pkg::*;
#(
  parameter int ANGLE_BITS = 16,
  parameter int VOLT_BITS  = 16,
  localparam int IN_W = ((2 * VOLT_BITS + ANGLE_BITS + 7) / 8) * 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [IN_W-1:0] s_tdata,   // volt_q, volt_d, elec_angle, zero fill
  input  logic            s_tuser,   // motor_index
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [47:0]     m_tdata,   // duty_a, duty_b, duty_c
  output logic            m_tuser,   // motor_out
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  localparam int V  = VOLT_BITS;
  localparam int AB = ANGLE_BITS;
  localparam int NW = 2 * VOLT_BITS;
  localparam int MW = (VOLT_BITS > 16) ? VOLT_BITS : 16;
  localparam int SH = 30 - VOLT_BITS;
  localparam int SA_W = NW + 2 + V + 32 + 1;

  typedef struct packed {
    logic [NW-1:0] n;
    logic          dzero;
    logic          negq;
    logic [V-1:0]  absq;
    logic [31:0]   ang;
    logic          motor;
  } atan_side_t;

  typedef struct packed {
    sector_t sec;
    logic    motor;
  } sin_side_t;

  // Configuration registers
  logic [15:0] supply_voltage;
  logic [15:0] pwm_period;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      supply_voltage <= SUPPLY_RESET;
      pwm_period     <= PERIOD_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(paddr[2]))
        REG_SUPPLY: supply_voltage <= pwdata[15:0];
        REG_PERIOD: pwm_period     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg_t'(paddr[2]))
      REG_SUPPLY: prdata = {16'b0, supply_voltage};
      REG_PERIOD: prdata = {16'b0, pwm_period};
      default:    prdata = '0;
    endcase
  end

  // Pipeline advance: the whole pipe moves while the skid entry is empty
  logic en;
  logic skid_valid;
  assign en       = !skid_valid;
  assign s_tready = en;

  // Stage P0: capture the command
  logic                p0_valid;
  logic signed [V-1:0] p0_q, p0_d;
  logic [AB-1:0]       p0_ang;
  logic                p0_motor;

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_valid <= 1'b0;
    end else if (en) begin
      p0_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_q     <= $signed(s_tdata[V-1:0]);
      p0_d     <= $signed(s_tdata[2*V-1:V]);
      p0_ang   <= s_tdata[2*V+AB-1:2*V];
      p0_motor <= s_tuser;
    end
  end

  // Stage P1: squares, sign handling and CORDIC start vector
  logic                 p1_valid;
  logic [NW-1:0]        p1_dd, p1_qq;
  logic                 p1_dzero, p1_negq, p1_motor;
  logic [V-1:0]         p1_absq;
  logic [31:0]          p1_ang;
  logic signed [CW-1:0] p1_x, p1_y, p1_z;
  logic signed [NW-1:0] dd_full, qq_full;
  logic signed [CW-1:0] d_ext, q_ext;

  assign dd_full = p0_d * p0_d;
  assign qq_full = p0_q * p0_q;
  assign d_ext   = CW'(p0_d);
  assign q_ext   = CW'(p0_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (en) begin
      p1_valid <= p0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_dd    <= unsigned'(dd_full);
      p1_qq    <= unsigned'(qq_full);
      p1_dzero <= (p0_d == '0);
      // The sign of q only matters on the q-only path
      p1_negq  <= (p0_d == '0) && p0_q[V-1];
      p1_absq  <= p0_q[V-1] ? unsigned'(-p0_q) : unsigned'(p0_q);
      p1_ang   <= {p0_ang, {(32 - AB){1'b0}}};
      p1_motor <= p0_motor;
      // Fold the left half plane over and start half a turn round
      if (p0_d[V-1]) begin
        p1_x <= (-d_ext) <<< SH;
        p1_y <= (-q_ext) <<< SH;
        p1_z <= $signed({{(CW-32){1'b0}}, 32'h8000_0000});
      end else begin
        p1_x <= d_ext <<< SH;
        p1_y <= q_ext <<< SH;
        p1_z <= '0;
      end
    end
  end

  // Stage P2: sum of squares
  logic                 p2_valid;
  atan_side_t           p2_side;
  logic signed [CW-1:0] p2_x, p2_y, p2_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (en) begin
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_side.n     <= p1_dd + p1_qq;
      p2_side.dzero <= p1_dzero;
      p2_side.negq  <= p1_negq;
      p2_side.absq  <= p1_absq;
      p2_side.ang   <= p1_ang;
      p2_side.motor <= p1_motor;
      p2_x          <= p1_x;
      p2_y          <= p1_y;
      p2_z          <= p1_z;
    end
  end

  // Phase of the voltage vector
  logic                 a_valid;
  logic signed [CW-1:0] a_y, a_z;
  atan_side_t           a_side;

  svpd_cordic #(
    .VECTORING (1'b1),
    .SIDE_W    (SA_W)
  ) u_atan (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p2_valid),
    .x_in      (p2_x),
    .y_in      (p2_y),
    .z_in      (p2_z),
    .side_in   (p2_side),
    .out_valid (a_valid),
    .y_out     (a_y),
    .z_out     (a_z),
    .side_out  (a_side)
  );

  logic [31:0] a_theta;
  assign a_theta = a_side.dzero ? (a_side.ang + QUARTER_TURN)
                                : (a_side.ang + a_z[31:0]);

  // Square root, one result bit per stage
  logic          sq_valid [1:V];
  logic [NW-1:0] sq_n     [1:V];
  logic [V+1:0]  sq_rem   [1:V];
  logic [V-1:0]  sq_root  [1:V];
  logic [31:0]   sq_theta [1:V];
  logic          sq_dzero [1:V];
  logic          sq_negq  [1:V];
  logic [V-1:0]  sq_absq  [1:V];
  logic          sq_motor [1:V];

  for (genvar k = 0; k < V; k++) begin : g_sqrt
    logic          vc, dzc, ngc, mc;
    logic [NW-1:0] nc;
    logic [V+1:0]  remc, r2, t, diff;
    logic [V-1:0]  rootc, absc;
    logic [31:0]   thc;
    logic          ge;

    if (k == 0) begin : g_first
      assign vc    = a_valid;
      assign nc    = a_side.n;
      assign remc  = '0;
      assign rootc = '0;
      assign thc   = a_theta;
      assign dzc   = a_side.dzero;
      assign ngc   = a_side.negq;
      assign absc  = a_side.absq;
      assign mc    = a_side.motor;
    end else begin : g_rest
      assign vc    = sq_valid[k];
      assign nc    = sq_n[k];
      assign remc  = sq_rem[k];
      assign rootc = sq_root[k];
      assign thc   = sq_theta[k];
      assign dzc   = sq_dzero[k];
      assign ngc   = sq_negq[k];
      assign absc  = sq_absq[k];
      assign mc    = sq_motor[k];
    end

    // Bring down the next bit pair and try the trial subtrahend
    assign r2   = {remc[V-1:0], nc[2*(V-1-k)+1 -: 2]};
    assign t    = {rootc, 2'b01};
    assign ge   = (r2 >= t);
    assign diff = r2 - t;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_valid[k+1] <= 1'b0;
      end else if (en) begin
        sq_valid[k+1] <= vc;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_n[k+1]     <= nc;
        sq_rem[k+1]   <= ge ? diff : r2;
        sq_root[k+1]  <= {rootc[V-2:0], ge};
        sq_theta[k+1] <= thc;
        sq_dzero[k+1] <= dzc;
        sq_negq[k+1]  <= ngc;
        sq_absq[k+1]  <= absc;
        sq_motor[k+1] <= mc;
      end
    end
  end

  // Divider set-up: pick the magnitude and detect saturation
  logic                 dv_valid [0:DIV_STEPS];
  logic [15:0]          dv_rem   [0:DIV_STEPS];
  logic [DIV_STEPS-1:0] dv_quo   [0:DIV_STEPS];
  logic                 dv_clamp [0:DIV_STEPS];
  logic                 dv_zz    [0:DIV_STEPS];
  logic                 dv_negq  [0:DIV_STEPS];
  logic [31:0]          dv_theta [0:DIV_STEPS];
  logic                 dv_motor [0:DIV_STEPS];
  logic [V-1:0]         mag;
  logic [MW-1:0]        magx, supx;
  logic                 sup_zero;

  assign mag      = sq_dzero[V] ? sq_absq[V] : sq_root[V];
  assign magx     = MW'(mag);
  assign supx     = MW'(supply_voltage);
  assign sup_zero = (supply_voltage == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else if (en) begin
      dv_valid[0] <= sq_valid[V];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem[0]   <= magx[15:0];
      dv_quo[0]   <= '0;
      dv_clamp[0] <= sup_zero ? (mag != '0) : (magx >= supx);
      dv_zz[0]    <= sup_zero;
      dv_negq[0]  <= sq_negq[V];
      dv_theta[0] <= sq_theta[V];
      dv_motor[0] <= sq_motor[V];
    end
  end

  // Restoring division, one quotient bit per stage
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [16:0] rem2, sub;
    logic        ge;

    assign rem2 = {dv_rem[j], 1'b0};
    assign ge   = (rem2 >= {1'b0, supply_voltage});
    assign sub  = rem2 - {1'b0, supply_voltage};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[j+1] <= 1'b0;
      end else if (en) begin
        dv_valid[j+1] <= dv_valid[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem[j+1]   <= ge ? sub[15:0] : rem2[15:0];
        dv_quo[j+1]   <= {dv_quo[j][DIV_STEPS-2:0], ge};
        dv_clamp[j+1] <= dv_clamp[j];
        dv_zz[j+1]    <= dv_zz[j];
        dv_negq[j+1]  <= dv_negq[j];
        dv_theta[j+1] <= dv_theta[j];
        dv_motor[j+1] <= dv_motor[j];
      end
    end
  end

  // Stage X1: modulation index and sector
  logic               x1_valid, x1_motor;
  sector_t            x1_sec;
  logic [31:0]        x1_r;
  logic signed [15:0] x1_su;
  logic [15:0]        u_quo, u_val;
  logic [34:0]        prod6;

  assign u_quo = 16'(dv_quo[DIV_STEPS]);
  assign prod6 = 35'({dv_theta[DIV_STEPS], 2'b00}) + 35'({dv_theta[DIV_STEPS], 1'b0});

  always_comb begin
    if (dv_clamp[DIV_STEPS]) begin
      u_val = U_LIMIT;
    end else if (dv_zz[DIV_STEPS]) begin
      u_val = '0;
    end else if (u_quo > U_LIMIT) begin
      u_val = U_LIMIT;
    end else begin
      u_val = u_quo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x1_valid <= 1'b0;
    end else if (en) begin
      x1_valid <= dv_valid[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_sec   <= sector_t'(prod6[34:32]);
      x1_r     <= prod6[31:0];
      x1_su    <= dv_negq[DIV_STEPS] ? -$signed(u_val) : $signed(u_val);
      x1_motor <= dv_motor[DIV_STEPS];
    end
  end

  // Stage X2: divide the in-sector position by six
  logic               x2_valid, x2_motor;
  sector_t            x2_sec;
  logic [63:0]        x2_m;
  logic [2:0]         x2_rlo;
  logic signed [15:0] x2_su;

  always_ff @(posedge clk) begin
    if (rst) begin
      x2_valid <= 1'b0;
    end else if (en) begin
      x2_valid <= x1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x2_m     <= 64'(x1_r) * 64'(DIV6_MAGIC);
      x2_rlo   <= x1_r[2:0];
      x2_sec   <= x1_sec;
      x2_su    <= x1_su;
      x2_motor <= x1_motor;
    end
  end

  // Stage X3: the two sector angles
  logic                 x3_valid, x3_motor;
  sector_t              x3_sec;
  logic signed [15:0]   x3_su;
  logic signed [CW-1:0] x3_z1, x3_z2;
  logic [29:0]          phi2;
  logic [2:0]           six_lo, rem6;
  logic [31:0]          phi1;

  assign phi2   = x2_m[63:34];
  assign six_lo = 3'(phi2[2:0] * 3'd6);
  assign rem6   = x2_rlo - six_lo;
  assign phi1   = SIXTH_TURN - 32'(phi2) - 32'(rem6 == 3'd5);

  always_ff @(posedge clk) begin
    if (rst) begin
      x3_valid <= 1'b0;
    end else if (en) begin
      x3_valid <= x2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x3_z1    <= $signed({{(CW-32){1'b0}}, phi1});
      x3_z2    <= $signed({{(CW-30){1'b0}}, phi2});
      x3_sec   <= x2_sec;
      x3_su    <= x2_su;
      x3_motor <= x2_motor;
    end
  end

  // Sines of both sector angles
  logic                 b_valid, c_valid;
  logic signed [CW-1:0] b_y, b_z, c_y, c_z;
  sin_side_t            b_side_in, b_side;
  logic [15:0]          c_side;

  assign b_side_in.sec   = x3_sec;
  assign b_side_in.motor = x3_motor;

  svpd_cordic #(
    .VECTORING (1'b0),
    .SIDE_W    ($bits(sin_side_t))
  ) u_sin1 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (x3_valid),
    .x_in      (CORDIC_K),
    .y_in      ('0),
    .z_in      (x3_z1),
    .side_in   (b_side_in),
    .out_valid (b_valid),
    .y_out     (b_y),
    .z_out     (b_z),
    .side_out  (b_side)
  );

  svpd_cordic #(
    .VECTORING (1'b0),
    .SIDE_W    (16)
  ) u_sin2 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (x3_valid),
    .x_in      (CORDIC_K),
    .y_in      ('0),
    .z_in      (x3_z2),
    .side_in   (unsigned'(x3_su)),
    .out_valid (c_valid),
    .y_out     (c_y),
    .z_out     (c_z),
    .side_out  (c_side)
  );

  // Stage K1: clip negative sines and scale by root three
  logic               k1_valid, k1_motor;
  sector_t            k1_sec;
  logic signed [15:0] k1_su;
  logic [31:0]        k1_k1, k1_k2;
  logic [31:0]        s1, s2;
  logic [63:0]        pk1, pk2;

  assign s1  = b_y[CW-1] ? '0 : b_y[31:0];
  assign s2  = c_y[CW-1] ? '0 : c_y[31:0];
  assign pk1 = 64'(s1) * 64'(SQRT3_Q30);
  assign pk2 = 64'(s2) * 64'(SQRT3_Q30);

  always_ff @(posedge clk) begin
    if (rst) begin
      k1_valid <= 1'b0;
    end else if (en) begin
      k1_valid <= b_valid && c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k1_k1    <= pk1[61:30];
      k1_k2    <= pk2[61:30];
      k1_sec   <= b_side.sec;
      k1_motor <= b_side.motor;
      k1_su    <= $signed(c_side);
    end
  end

  // Stage K2: active vector times, scaled by the modulation index
  logic                 k2_valid, k2_motor;
  sector_t              k2_sec;
  logic signed [CW-1:0] k2_t1, k2_t2;
  logic signed [48:0]   pt1, pt2;

  assign pt1 = $signed({1'b0, k1_k1}) * k1_su;
  assign pt2 = $signed({1'b0, k1_k2}) * k1_su;

  always_ff @(posedge clk) begin
    if (rst) begin
      k2_valid <= 1'b0;
    end else if (en) begin
      k2_valid <= k1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k2_t1    <= pt1[48:15];
      k2_t2    <= pt2[48:15];
      k2_sec   <= k1_sec;
      k2_motor <= k1_motor;
    end
  end

  // Stage K3: half of the zero vector time
  logic                 k3_valid, k3_motor;
  sector_t              k3_sec;
  logic signed [CW-1:0] k3_t1, k3_t2, k3_h;
  logic signed [CW+1:0] t0;

  assign t0 = $signed({5'b0, ONE_Q30}) - k2_t1 - k2_t2;

  always_ff @(posedge clk) begin
    if (rst) begin
      k3_valid <= 1'b0;
    end else if (en) begin
      k3_valid <= k2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k3_t1    <= k2_t1;
      k3_t2    <= k2_t2;
      k3_h     <= CW'(t0 >>> 1);
      k3_sec   <= k2_sec;
      k3_motor <= k2_motor;
    end
  end

  // Stage K4: phase times by sector
  logic                 k4_valid, k4_motor;
  logic [30:0]          k4_ta, k4_tb, k4_tc;
  logic signed [CW+1:0] all_h, t1_h, t2_h, h_only;
  logic signed [CW+1:0] ta, tb, tc;

  assign all_h  = k3_t1 + k3_t2 + k3_h;
  assign t1_h   = k3_t1 + k3_h;
  assign t2_h   = k3_t2 + k3_h;
  assign h_only = (CW+2)'(k3_h);

  always_comb begin
    case (k3_sec)
      SEC_1: begin ta = all_h;  tb = t2_h;   tc = h_only; end
      SEC_2: begin ta = t1_h;   tb = all_h;  tc = h_only; end
      SEC_3: begin ta = h_only; tb = all_h;  tc = t2_h;   end
      SEC_4: begin ta = h_only; tb = t1_h;   tc = all_h;  end
      SEC_5: begin ta = t2_h;   tb = h_only; tc = all_h;  end
      SEC_6: begin ta = all_h;  tb = h_only; tc = t1_h;   end
      default: begin ta = '0; tb = '0; tc = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k4_valid <= 1'b0;
    end else if (en) begin
      k4_valid <= k3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k4_ta    <= clamp_time(ta);
      k4_tb    <= clamp_time(tb);
      k4_tc    <= clamp_time(tc);
      k4_motor <= k3_motor;
    end
  end

  // Stage K5: scale to the PWM period
  logic        k5_valid;
  duty_t       k5_data;
  logic [46:0] pa, pb, pc;

  assign pa = 47'(k4_ta) * 47'(pwm_period);
  assign pb = 47'(k4_tb) * 47'(pwm_period);
  assign pc = 47'(k4_tc) * 47'(pwm_period);

  always_ff @(posedge clk) begin
    if (rst) begin
      k5_valid <= 1'b0;
    end else if (en) begin
      k5_valid <= k4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k5_data.duty_a <= pa[45:30];
      k5_data.duty_b <= pb[45:30];
      k5_data.duty_c <= pc[45:30];
      k5_data.motor  <= k4_motor;
    end
  end

  // Output register with one skid entry behind it
  logic  out_valid;
  duty_t out_data, skid_data;
  logic  out_held;

  assign out_held = out_valid && !m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_held) begin
      if (en && k5_valid) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= k5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_held) begin
      if (en) begin
        skid_data <= k5_data;
      end
    end else if (skid_valid) begin
      out_data <= skid_data;
    end else begin
      out_data <= k5_data;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_data.duty_c, out_data.duty_b, out_data.duty_a};
  assign m_tuser  = out_data.motor;

`ifndef ASSERT_OFF
  // The skid entry is only ever occupied behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds data with the output register empty");

  // A held result must not have let a second item into a full skid entry
  a_skid_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_held) |=> skid_valid && $stable(skid_data))
    else $error("skid entry overwritten while the output stalls");

  // Duties never exceed the PWM period
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.duty_a <= pwm_period) && (out_data.duty_b <= pwm_period)
                  && (out_data.duty_c <= pwm_period))
    else $error("duty above PWM period");

  // The two sector angles together never pass one sixth of a turn
  a_sector_split: assert property (@(posedge clk) disable iff (rst)
    x3_valid |-> (33'(x3_z1[31:0]) + 33'(x3_z2[31:0])) <= 33'(SIXTH_TURN))
    else $error("sector angles exceed one sixth of a turn");
`endif

endmodule

@@ design/svpd_cordic.sv @@
// Pipelined CORDIC, one micro-rotation per stage, vectoring or rotation mode.
module svpd_cordic
  import svpd_pkg::*;
#(
  parameter bit VECTORING = 1'b0,
  parameter int SIDE_W    = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [CW-1:0] x_in,
  input  logic signed [CW-1:0] y_in,
  input  logic signed [CW-1:0] z_in,
  input  logic [SIDE_W-1:0]    side_in,
  output logic                 out_valid,
  output logic signed [CW-1:0] y_out,
  output logic signed [CW-1:0] z_out,
  output logic [SIDE_W-1:0]    side_out
);

  logic                 v    [1:CORDIC_STEPS];
  logic signed [CW-1:0] x    [1:CORDIC_STEPS];
  logic signed [CW-1:0] y    [1:CORDIC_STEPS];
  logic signed [CW-1:0] z    [1:CORDIC_STEPS];
  logic [SIDE_W-1:0]    side [1:CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic                 vc;
    logic signed [CW-1:0] xc, yc, zc, xs, ys, ang;
    logic [SIDE_W-1:0]    sc;
    logic                 pos;

    if (i == 0) begin : g_first
      assign vc = in_valid;
      assign xc = x_in;
      assign yc = y_in;
      assign zc = z_in;
      assign sc = side_in;
    end else begin : g_rest
      assign vc = v[i];
      assign xc = x[i];
      assign yc = y[i];
      assign zc = z[i];
      assign sc = side[i];
    end

    // Pick the rotation direction: drive y to zero or z to zero
    assign pos = VECTORING ? yc[CW-1] : !zc[CW-1];
    assign xs  = xc >>> i;
    assign ys  = yc >>> i;
    assign ang = $signed({{(CW-32){1'b0}}, ATAN_TURN[i]});

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= vc;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (pos) begin
          x[i+1] <= xc - ys;
          y[i+1] <= yc + xs;
          z[i+1] <= zc - ang;
        end else begin
          x[i+1] <= xc + ys;
          y[i+1] <= yc - xs;
          z[i+1] <= zc + ang;
        end
        side[i+1] <= sc;
      end
    end
  end

  assign out_valid = v[CORDIC_STEPS];
  assign y_out     = y[CORDIC_STEPS];
  assign z_out     = z[CORDIC_STEPS];
  assign side_out  = side[CORDIC_STEPS];

endmodule
